[sv/hufd_pkg.sv]
// ----------------------------------------------------------------------------
// Huffman decoder package
// Field widths, item action codes and the structs that pass between the
// decoder control and its code table.
// ----------------------------------------------------------------------------
package hufd_pkg;

   localparam int ACTION_W    = 2;
   localparam int INDEX_W     = 8;
   localparam int SYMBOL_W    = 8;
   localparam int ENTRY_LEN_W = 6;
   localparam int CODE_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int BITS_W      = 4;

   localparam int DEF_TABLE_DEPTH  = 256;
   localparam int DEF_MAX_CODE_LEN = 32;

   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DATA  = 2'd2;

   // Table maintenance request: a clear or a write of one entry.
   typedef struct packed {
      logic                   clear;
      logic                   load;
      logic [INDEX_W-1:0]     index;
      logic [SYMBOL_W-1:0]    symbol;
      logic [ENTRY_LEN_W-1:0] length;
      logic [CODE_W-1:0]      code;
   } hufd_load_type;

   // Outcome of one table search, valid for the single cycle of done.
   typedef struct packed {
      logic                done;
      logic                hit;
      logic [SYMBOL_W-1:0] symbol;
   } hufd_scan_type;

endpackage

[sv/hufd_table.sv]
// ----------------------------------------------------------------------------
// Huffman decoder code table
// Holds the code entries in a memory with per-slot valid bits and searches
// them one slot per cycle, lowest slot first, for the current partial code.
// ----------------------------------------------------------------------------
module hufd_table
   import hufd_pkg::*;
#(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hufd_load_type                    load,
   input  logic                             scan_start,
   input  logic [$clog2(MAX_CODE_LEN+1)-1:0] scan_len,
   input  logic [MAX_CODE_LEN-1:0]          scan_code,
   output hufd_scan_type                    scan_rsp
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
   localparam int LCMP_W = (LEN_W > ENTRY_LEN_W) ? LEN_W : ENTRY_LEN_W;
   localparam int KEY_W  = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int ENT_W  = SYMBOL_W + ENTRY_LEN_W + CODE_W;

   logic [ENT_W-1:0]       mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   any_ff, any_in;
   logic [IDX_W-1:0]       limit_ff, limit_in;
   logic [ENTRY_LEN_W-1:0] max_len_ff, max_len_in;
   logic                   issue_ff, issue_in;
   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic                   rd_pend_ff, rd_pend_in;
   logic                   rd_last_ff, rd_last_in;
   logic [ENT_W-1:0]       rd_data_ff;
   logic                   rd_vld_ff;
   hufd_scan_type          scan_rsp_ff, scan_rsp_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_idx;
   logic [SYMBOL_W-1:0]    rd_symbol;
   logic [ENTRY_LEN_W-1:0] rd_len;
   logic [CODE_W-1:0]      rd_code;
   logic [CODE_W-1:0]      rd_masked;
   logic                   match;
   logic                   skip;

   assign wr_en  = load.load && ({1'b0, load.index} < (INDEX_W+1)'(TABLE_DEPTH));
   assign wr_idx = load.index[IDX_W-1:0];
   assign {rd_symbol, rd_len, rd_code} = rd_data_ff;

   always_comb begin
      for (int i = 0; i < CODE_W; i++) begin
         rd_masked[i] = rd_code[i] & (6'(i) < rd_len);
      end
   end

   assign match = rd_pend_ff && rd_vld_ff
                  && (LCMP_W'(rd_len) == LCMP_W'(scan_len))
                  && (KEY_W'(rd_masked) == KEY_W'(scan_code));

   // A partial code longer than every loaded code cannot match anything.
   assign skip = !any_ff || (LCMP_W'(scan_len) > LCMP_W'(max_len_ff));

   always_comb begin
      valid_in    = valid_ff;
      any_in      = any_ff;
      limit_in    = limit_ff;
      max_len_in  = max_len_ff;
      issue_in    = issue_ff;
      addr_in     = addr_ff;
      rd_pend_in  = issue_ff;
      rd_last_in  = (addr_ff == limit_ff);
      scan_rsp_in = '0;

      if (load.clear) begin
         valid_in   = '0;
         any_in     = 1'b0;
         limit_in   = '0;
         max_len_in = '0;
      end else if (wr_en) begin
         valid_in[wr_idx] = 1'b1;
         any_in           = 1'b1;
         if (!any_ff || wr_idx > limit_ff) begin
            limit_in = wr_idx;
         end
         if (!any_ff || load.length > max_len_ff) begin
            max_len_in = load.length;
         end
      end

      if (scan_start) begin
         if (skip) begin
            scan_rsp_in.done = 1'b1;
         end else begin
            issue_in = 1'b1;
            addr_in  = '0;
         end
      end else if (issue_ff) begin
         if (addr_ff == limit_ff) begin
            issue_in = 1'b0;
         end else begin
            addr_in = addr_ff + IDX_W'(1);
         end
      end

      if (rd_pend_ff) begin
         if (match) begin
            scan_rsp_in.done   = 1'b1;
            scan_rsp_in.hit    = 1'b1;
            scan_rsp_in.symbol = rd_symbol;
            issue_in           = 1'b0;
            rd_pend_in         = 1'b0;
         end else if (rd_last_ff) begin
            scan_rsp_in.done = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      limit_ff   <= limit_in;
      max_len_ff <= max_len_in;
      addr_ff    <= addr_in;
      rd_last_ff <= rd_last_in;
      if (reset) begin
         valid_ff    <= '0;
         any_ff      <= 1'b0;
         issue_ff    <= 1'b0;
         rd_pend_ff  <= 1'b0;
         scan_rsp_ff <= '0;
      end else begin
         valid_ff    <= valid_in;
         any_ff      <= any_in;
         issue_ff    <= issue_in;
         rd_pend_ff  <= rd_pend_in;
         scan_rsp_ff <= scan_rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= {load.symbol, load.length, load.code};
      end
      if (issue_ff) begin
         rd_data_ff <= mem[addr_ff];
         rd_vld_ff  <= valid_ff[addr_ff];
      end
   end

   assign scan_rsp = scan_rsp_ff;

endmodule

[sv/huffman_table_bit_decoder.sv]
// ----------------------------------------------------------------------------
// Huffman table bit decoder
// Loads a Huffman code table entry by entry and decodes a byte stream against
// it one bit at a time, giving one result item per decoded symbol or error.
// ----------------------------------------------------------------------------
// A clear item and a load item give no result. A data item shifts its valid
// bits, most significant first, into the partial code, one bit per step. Each
// step is a shift, a search of the code table and a hand-on of the result,
// which may wait while the output register is full and stalled. The search
// reads one table slot per cycle from slot zero up to the highest slot loaded
// since the last clear and stops at the first match; it reads no slot at all
// when the partial code is longer than every loaded code. The table search, a
// single memory read port, sets the decoding speed. The block takes one item
// at a time and accepts the next one as soon as the previous data byte is
// finished and its last result has moved into the output register; a result
// that is then still waiting in the output register does not hold up the
// input. The result that was found last for a byte is kept back until the
// byte ends, so that it can carry the last flag.
// ----------------------------------------------------------------------------
module huffman_table_bit_decoder
   import hufd_pkg::*;
#(
   parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
   parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [ACTION_W-1:0]    req_action,
   input  logic [INDEX_W-1:0]     req_entry_index,
   input  logic [SYMBOL_W-1:0]    req_entry_symbol,
   input  logic [ENTRY_LEN_W-1:0] req_entry_length,
   input  logic [CODE_W-1:0]      req_entry_code,
   input  logic [BYTE_W-1:0]      req_data_byte,
   input  logic [BITS_W-1:0]      req_bits_valid,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SYMBOL_W-1:0]    rsp_symbol,
   output logic                   rsp_code_error,
   output logic                   rsp_last
);

   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_WAIT,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   logic [BYTE_W-1:0]       byte_ff, byte_in;
   logic [BITS_W-1:0]       bits_left_ff, bits_left_in;
   logic [MAX_CODE_LEN-1:0] pcode_ff, pcode_in;
   logic [LEN_W-1:0]        plen_ff, plen_in;
   logic                    scan_start_ff, scan_start_in;

   // The newest result of the current byte, waiting for the next one.
   logic                    new_vld_ff, new_vld_in;
   logic [SYMBOL_W-1:0]     new_sym_ff, new_sym_in;
   logic                    new_err_ff, new_err_in;
   logic                    pend_vld_ff, pend_vld_in;
   logic [SYMBOL_W-1:0]     pend_sym_ff, pend_sym_in;
   logic                    pend_err_ff, pend_err_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0]     rsp_symbol_ff, rsp_symbol_in;
   logic                    rsp_code_error_ff, rsp_code_error_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_accept;
   logic                    out_free;
   hufd_load_type           tbl_load;
   hufd_scan_type           scan_rsp;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign tbl_load.clear  = req_accept && (req_action == ACT_CLEAR);
   assign tbl_load.load   = req_accept && (req_action == ACT_LOAD);
   assign tbl_load.index  = req_entry_index;
   assign tbl_load.symbol = req_entry_symbol;
   assign tbl_load.length = req_entry_length;
   assign tbl_load.code   = req_entry_code;

   hufd_table #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .load       (tbl_load),
      .scan_start (scan_start_ff),
      .scan_len   (plen_ff),
      .scan_code  (pcode_ff),
      .scan_rsp   (scan_rsp)
   );

   always_comb begin
      state_in          = state_ff;
      byte_in           = byte_ff;
      bits_left_in      = bits_left_ff;
      pcode_in          = pcode_ff;
      plen_in           = plen_ff;
      scan_start_in     = 1'b0;
      new_vld_in        = new_vld_ff;
      new_sym_in        = new_sym_ff;
      new_err_in        = new_err_ff;
      pend_vld_in       = pend_vld_ff;
      pend_sym_in       = pend_sym_ff;
      pend_err_in       = pend_err_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_symbol_in     = rsp_symbol_ff;
      rsp_code_error_in = rsp_code_error_ff;
      rsp_last_in       = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_action)
                  ACT_CLEAR: begin
                     pcode_in = '0;
                     plen_in  = '0;
                  end
                  ACT_DATA: begin
                     byte_in      = req_data_byte;
                     bits_left_in = (req_bits_valid > BITS_W'(BYTE_W)) ?
                                    BITS_W'(BYTE_W) : req_bits_valid;
                     if (req_bits_valid != '0) begin
                        state_in = ST_SHIFT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SHIFT: begin
            pcode_in      = {pcode_ff[MAX_CODE_LEN-2:0], byte_ff[BYTE_W-1]};
            plen_in       = plen_ff + LEN_W'(1);
            byte_in       = {byte_ff[BYTE_W-2:0], 1'b0};
            bits_left_in  = bits_left_ff - BITS_W'(1);
            scan_start_in = 1'b1;
            state_in      = ST_WAIT;
         end

         ST_WAIT: begin
            if (scan_rsp.done) begin
               // A match wins over the error at the maximum length.
               if (scan_rsp.hit) begin
                  new_vld_in = 1'b1;
                  new_sym_in = scan_rsp.symbol;
                  new_err_in = 1'b0;
                  pcode_in   = '0;
                  plen_in    = '0;
               end else if (plen_ff == LEN_W'(MAX_CODE_LEN)) begin
                  new_vld_in = 1'b1;
                  new_sym_in = '0;
                  new_err_in = 1'b1;
                  pcode_in   = '0;
                  plen_in    = '0;
               end
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (!new_vld_ff || !pend_vld_ff || out_free) begin
               if (new_vld_ff) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in      = 1'b1;
                     rsp_symbol_in     = pend_sym_ff;
                     rsp_code_error_in = pend_err_ff;
                     rsp_last_in       = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_sym_in = new_sym_ff;
                  pend_err_in = new_err_ff;
                  new_vld_in  = 1'b0;
               end
               state_in = (bits_left_ff == '0) ? ST_FLUSH : ST_SHIFT;
            end
         end

         ST_FLUSH: begin
            if (!pend_vld_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_symbol_in     = pend_sym_ff;
               rsp_code_error_in = pend_err_ff;
               rsp_last_in       = 1'b1;
               pend_vld_in       = 1'b0;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      byte_ff           <= byte_in;
      bits_left_ff      <= bits_left_in;
      new_sym_ff        <= new_sym_in;
      new_err_ff        <= new_err_in;
      pend_sym_ff       <= pend_sym_in;
      pend_err_ff       <= pend_err_in;
      rsp_symbol_ff     <= rsp_symbol_in;
      rsp_code_error_ff <= rsp_code_error_in;
      rsp_last_ff       <= rsp_last_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         pcode_ff      <= '0;
         plen_ff       <= '0;
         scan_start_ff <= 1'b0;
         new_vld_ff    <= 1'b0;
         pend_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pcode_ff      <= pcode_in;
         plen_ff       <= plen_in;
         scan_start_ff <= scan_start_in;
         new_vld_ff    <= new_vld_in;
         pend_vld_ff   <= pend_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_symbol     = rsp_symbol_ff;
   assign rsp_code_error = rsp_code_error_ff;
   assign rsp_last       = rsp_last_ff;

   // The partial code never grows past the maximum code length.
   assert property (@(posedge clock) disable iff (reset)
      plen_ff <= LEN_W'(MAX_CODE_LEN))
      else $error("partial code longer than the maximum code length");

   // A search is started only on the way into the wait state.
   assert property (@(posedge clock) disable iff (reset)
      scan_start_ff |-> state_ff == ST_WAIT)
      else $error("table search started outside the wait state");

   // The table answers only while the control waits for it.
   assert property (@(posedge clock) disable iff (reset)
      scan_rsp.done |-> state_ff == ST_WAIT)
      else $error("table search result arrived unexpectedly");

   // No result of a byte may be left behind once the block is idle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_vld_ff && !new_vld_ff)
      else $error("held result left over at the end of a byte");

endmodule
